[rtl/ird_pkg.sv]
// ----------------------------------------------------------------------------
// ird_pkg
// Shared sizes, register codes, digit struct and character lookup for the
// integer-to-radix digit converter.
// ----------------------------------------------------------------------------
package ird_pkg;

  // Sizes
  localparam int VALUE_BITS = 64;
  localparam int MAX_DIGITS = 64;
  localparam int IN_W       = 64;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int OUT_W      = 8;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Register map (word index taken from paddr[2])
  localparam logic REG_IDX_RADIX = 1'b0;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A_OFS = 7'd87;  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CHAR_ERROR = 7'h00;

  // One digit beat from the divider to the digit buffer
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [DIGIT_W-1:0] value;
  } ird_digit_t;

  // Clamp a written radix into the legal range
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] w);
    logic [RADIX_W-1:0] r;
    r = w;
    if (w < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (w > RADIX_MAX) begin
      r = RADIX_MAX;
    end
    return r;
  endfunction

  // Map a digit value to its ASCII character, 0-9 then a-z
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {1'b0, d};
    end else if (d < 6'd36) begin
      c = CHAR_A_OFS + {1'b0, d};
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

[rtl/integer_to_radix_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts one signed integer per beat into its digits in a programmable
// radix (2..36), most significant digit first, as lower-case ASCII.
// ----------------------------------------------------------------------------
//
//  Channel    | Dir | Handshake              | Payload
//  -----------+-----+------------------------+-----------------------------------
//  s_axis     | in  | tvalid / tready        | tdata[63:0] value
//  m_axis     | out | tvalid / tready        | tdata[6:0] digit_char, tlast
//             |     |                        |   last_digit, tuser negative_error
//  apb        | in  | psel / penable / pready| reg 0 @ 0x0: out_radix[5:0]
//
//  Each digit of a value is worked out in the shared shift-subtract
//  divider (one quotient bit a cycle), then read back from the digit
//  memory through the S_READ and S_LOAD states.
//  A negative value gives its single error beat in the cycle after acceptance.
//  One value is in flight at a time; s_axis_tready_o returns high the cycle
//  after the last beat of a value is taken. Low m_axis_tready_i holds the
//  output register and stalls the read-back. Reset is asynchronous; the digit
//  memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_radix_digits (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ird_pkg::IN_W-1:0]       s_axis_tdata_i,   // [63:0] value
  // Output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ird_pkg::OUT_W-1:0]      m_axis_tdata_o,   // [6:0] digit_char, [7] zero
  output logic                           m_axis_tlast_o,
  output logic                           m_axis_tuser_o,   // [0] negative_error
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ird_pkg::APB_AW-1:0]     paddr,
  input  logic [ird_pkg::APB_DW-1:0]     pwdata,
  output logic [ird_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  logic [ird_pkg::RADIX_W-1:0]     radix_q;
  logic                            busy_q;
  logic                            in_beat;
  logic                            negative;
  logic                            cfg_wr;
  logic                            done;
  logic [ird_pkg::CHAR_W-1:0]      out_char;
  ird_pkg::ird_digit_t             digit;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == ird_pkg::REG_IDX_RADIX);
  assign prdata = {{(ird_pkg::APB_DW-ird_pkg::RADIX_W){1'b0}}, radix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= ird_pkg::RADIX_RESET;
    end else if (cfg_wr) begin
      radix_q <= ird_pkg::clamp_radix(pwdata[ird_pkg::RADIX_W-1:0]);
    end
  end

  // Accept one value at a time; hold off until its last beat is taken
  assign s_axis_tready_o = !busy_q;
  assign in_beat         = s_axis_tvalid_i && !busy_q;
  assign negative        = s_axis_tdata_i[ird_pkg::VALUE_BITS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_beat) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  ird_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_beat && !negative),
    .value_i (s_axis_tdata_i[ird_pkg::VALUE_BITS-1:0]),
    .radix_i (radix_q),
    .digit_o (digit)
  );

  ird_digit_buf u_digit_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .digit_i     (digit),
    .err_i       (in_beat && negative),
    .done_o      (done),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o),
    .out_err_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(ird_pkg::OUT_W-ird_pkg::CHAR_W){1'b0}}, out_char};

endmodule

[rtl/ird_divider.sv]
// ----------------------------------------------------------------------------
// ird_divider
// Bit-serial restoring divider: repeatedly divides the value by the radix,
// one quotient bit per cycle, and hands out each remainder as a digit,
// least significant digit first.
// ----------------------------------------------------------------------------
module ird_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [ird_pkg::VALUE_BITS-1:0]       value_i,
  input  logic [ird_pkg::RADIX_W-1:0]          radix_i,
  output ird_pkg::ird_digit_t                  digit_o
);

  logic                                  busy_q, busy_d;
  logic [ird_pkg::VALUE_BITS-1:0]        quot_q, quot_d;
  logic [ird_pkg::DIGIT_W-1:0]           rem_q, rem_d;
  logic [ird_pkg::RADIX_W-1:0]           radix_q, radix_d;
  logic [ird_pkg::BIT_CNT_W-1:0]         bit_cnt_q, bit_cnt_d;
  logic [ird_pkg::ADDR_W-1:0]            ndig_q, ndig_d;

  logic [ird_pkg::DIGIT_W:0]             trial;
  logic                                  fits;
  logic [ird_pkg::DIGIT_W-1:0]           rem_nxt;
  logic [ird_pkg::VALUE_BITS-1:0]        quot_nxt;
  logic                                  digit_end;
  logic                                  run_last;

  // Shift the next dividend bit into the remainder and trial-subtract
  assign trial    = {rem_q, quot_q[ird_pkg::VALUE_BITS-1]};
  assign fits     = trial >= {1'b0, radix_q};
  assign rem_nxt  = fits ? ird_pkg::DIGIT_W'(trial - {1'b0, radix_q})
                         : trial[ird_pkg::DIGIT_W-1:0];
  assign quot_nxt = {quot_q[ird_pkg::VALUE_BITS-2:0], fits};

  assign digit_end = busy_q && (bit_cnt_q == ird_pkg::BIT_CNT_W'(ird_pkg::VALUE_BITS-1));
  assign run_last  = (quot_nxt == '0) ||
                     (ndig_q == ird_pkg::ADDR_W'(ird_pkg::MAX_DIGITS-1));

  // Sequence the division passes
  always_comb begin
    busy_d    = busy_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    radix_d   = radix_q;
    bit_cnt_d = bit_cnt_q;
    ndig_d    = ndig_q;
    if (start_i) begin
      busy_d    = 1'b1;
      quot_d    = value_i;
      rem_d     = '0;
      radix_d   = radix_i;
      bit_cnt_d = '0;
      ndig_d    = '0;
    end else if (busy_q) begin
      quot_d = quot_nxt;
      if (digit_end) begin
        rem_d     = '0;
        bit_cnt_d = '0;
        ndig_d    = ndig_q + 1'b1;
        busy_d    = !run_last;
      end else begin
        rem_d     = rem_nxt;
        bit_cnt_d = bit_cnt_q + 1'b1;
      end
    end
  end

  // Hand out the finished remainder as a digit
  assign digit_o.valid = digit_end;
  assign digit_o.last  = run_last;
  assign digit_o.value = rem_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      bit_cnt_q <= '0;
      ndig_q    <= '0;
    end else begin
      busy_q    <= busy_d;
      bit_cnt_q <= bit_cnt_d;
      ndig_q    <= ndig_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
  end

endmodule

[rtl/ird_digit_buf.sv]
// ----------------------------------------------------------------------------
// ird_digit_buf
// Digit memory and output stage: collects digits least significant first,
// then reads them back in reverse order and presents them as character
// beats. Also presents the single error beat for a negative value.
// ----------------------------------------------------------------------------
module ird_digit_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ird_pkg::ird_digit_t           digit_i,
  input  logic                          err_i,
  output logic                          done_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ird_pkg::CHAR_W-1:0]    out_char_o,
  output logic                          out_last_o,
  output logic                          out_err_o
);

  typedef enum logic [1:0] {
    S_FILL,
    S_READ,
    S_LOAD,
    S_DRAIN
  } state_e;

  state_e                       state_q;
  logic [ird_pkg::ADDR_W-1:0]   wr_ptr_q;
  logic [ird_pkg::ADDR_W-1:0]   rd_ptr_q;
  logic                         out_valid_q;
  logic [ird_pkg::CHAR_W-1:0]   out_char_q;
  logic                         out_last_q;
  logic                         out_err_q;

  logic [ird_pkg::DIGIT_W-1:0]  mem [ird_pkg::MAX_DIGITS];
  logic [ird_pkg::DIGIT_W-1:0]  rd_data_q;
  logic                         rd_en;
  logic                         beat_taken;
  logic                         slot_free;

  assign beat_taken = out_valid_q && out_ready_i;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign rd_en      = (state_q == S_READ);

  // Digit memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (digit_i.valid) begin
      mem[wr_ptr_q] <= digit_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  // Fill, read back most significant first, and drive the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_FILL: begin
          if (err_i) begin
            out_valid_q <= 1'b1;
            out_char_q  <= ird_pkg::CHAR_ERROR;
            out_last_q  <= 1'b1;
            out_err_q   <= 1'b1;
            state_q     <= S_DRAIN;
          end else if (digit_i.valid) begin
            if (digit_i.last) begin
              rd_ptr_q <= wr_ptr_q;
              state_q  <= S_READ;
            end else begin
              wr_ptr_q <= wr_ptr_q + 1'b1;
            end
          end
        end
        S_READ: begin
          if (beat_taken) begin
            out_valid_q <= 1'b0;
          end
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= ird_pkg::digit_to_char(rd_data_q);
            out_last_q  <= (rd_ptr_q == '0);
            out_err_q   <= 1'b0;
            if (rd_ptr_q == '0) begin
              state_q <= S_DRAIN;
            end else begin
              rd_ptr_q <= rd_ptr_q - 1'b1;
              state_q  <= S_READ;
            end
          end
        end
        S_DRAIN: begin
          if (beat_taken) begin
            out_valid_q <= 1'b0;
          end
          if (beat_taken && out_last_q) begin
            wr_ptr_q <= '0;
            state_q  <= S_FILL;
          end
        end
        default: begin
          state_q <= S_FILL;
        end
      endcase
    end
  end

  // Flag the run as finished on the edge that takes its last beat
  assign done_o      = (state_q == S_DRAIN) && beat_taken && out_last_q;
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

endmodule

[rtl/ird_checker.sv]
// ----------------------------------------------------------------------------
// ird_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module ird_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_o,
  input  logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic [ird_pkg::OUT_W-1:0]      m_axis_tdata_o,
  input  logic                           m_axis_tlast_o,
  input  logic                           m_axis_tuser_o
);

  // Drop input ready for the beat after a value is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready stayed high after accepting a value");

  // Reopen the input right after the last beat of a value leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("input not ready after final beat");

  // Error beat is a last beat with a zero character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("malformed error beat");

  // Digit beats carry only 0-9 or a-z
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      ((m_axis_tdata_o >= 8'h30 && m_axis_tdata_o <= 8'h39) ||
       (m_axis_tdata_o >= 8'h61 && m_axis_tdata_o <= 8'h7a)))
    else $error("digit character out of range");

  // Hold a pending output beat until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output beat dropped or changed while stalled");

endmodule

bind integer_to_radix_digits ird_checker u_ird_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
